// File: src/rmv_pkg.sv
// ----------------------------------------------------------------------------
// rmv_pkg
// Types, constants and codes shared by the running mean / variance block.
// ----------------------------------------------------------------------------
package rmv_pkg;

  // Field widths
  localparam int SAMPLE_W  = 32;                   // used bits of a sample, 8..32
  localparam int FRAC_W    = 16;                   // fraction bits of the mean
  localparam int CNT_W     = 32;
  localparam int SMP_W     = 32;                   // sample field width
  localparam int MEAN_W    = SMP_W + FRAC_W;       // 48
  localparam int SUM_W     = 64;
  localparam int PROD_W    = 2 * MEAN_W;           // full product width, 96
  localparam int ALU_W     = 64;

  // Iteration counts of the shared unit
  localparam int DIV_STEPS = SUM_W;                // quotient bits per divide
  localparam int MUL_STEPS = MEAN_W;               // multiplier bits per multiply
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic               command;
    logic [SMP_W-1:0]   sample;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]   sample_total;
    logic [MEAN_W-1:0]  mean_value;
    logic [SUM_W-1:0]   variance_value;
    logic [SMP_W-1:0]   smallest_seen;
    logic [SMP_W-1:0]   largest_seen;
    logic [SUM_W-1:0]   value_sum;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMP,
    ST_MAG,
    ST_DIV,
    ST_MEAN,
    ST_D2,
    ST_MUL,
    ST_ACC,
    ST_VDIV,
    ST_FIN
  } state_t;

  typedef enum logic {
    OP_ADD,
    OP_SUB
  } alu_op_t;

  typedef struct packed {
    logic               carry;   // carry out on add, borrow on subtract
    logic [ALU_W-1:0]   value;
  } alu_res_t;

  // Control from the port side to the sequencer
  typedef struct packed {
    logic start;
    logic taken;
  } core_ctl_t;

  // Status from the sequencer to the port side
  typedef struct packed {
    logic idle;
    logic done;
  } core_stat_t;

endpackage

// File: src/running_mean_variance_stats.sv
// ----------------------------------------------------------------------------
// running_mean_variance_stats
// Welford running mean and population variance over unsigned samples, with
// count, min, max and total.
//
//   channel   valid          stall          item
//   sample    sample_valid   sample_stall   sample_item (command, sample)
//   stats     stats_valid    stats_stall    stats_item  (six statistics)
//
// A sample item runs from acceptance to its result in the output register
// through the compare and magnitude states, 64 divide steps for the mean,
// the mean and deviation updates, 48 multiply steps, an accumulate and 64
// divide steps for the variance, all on the one shared 64-bit adder. A clear
// item skips the arithmetic. Reset zeros all statistics. A result held by
// stats_stall makes the core wait with its next result, accepting no new item.
// ----------------------------------------------------------------------------
module running_mean_variance_stats import rmv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      sample_valid,
  output logic      sample_stall,
  input  in_item_t  sample_item,
  output logic      stats_valid,
  input  logic      stats_stall,
  output out_item_t stats_item
);

  core_ctl_t  ctl;
  core_stat_t stat;
  out_item_t  result;
  logic       load;

  rmv_core u_core (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .item   (sample_item),
    .stat   (stat),
    .result (result)
  );

  assign sample_stall = !stat.idle;
  assign load         = stat.done && (!stats_valid || !stats_stall);
  assign ctl.start    = sample_valid && stat.idle;
  assign ctl.taken    = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      stats_valid <= 1'b0;
    end else if (load) begin
      stats_valid <= 1'b1;
    end else if (!stats_stall) begin
      stats_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stats_item <= result;
    end
  end

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    stats_valid |-> stats_item.smallest_seen <= stats_item.largest_seen)
    else $error("smallest_seen above largest_seen");

  a_var_zero: assert property (@(posedge clk) disable iff (rst)
    stats_valid && stats_item.sample_total < CNT_W'(2) |-> stats_item.variance_value == '0)
    else $error("variance nonzero below two samples");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    stats_valid && stats_item.sample_total == '0
      |-> stats_item.value_sum == '0 && stats_item.mean_value == '0)
    else $error("statistics nonzero with no samples");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("second item accepted while busy");

endmodule

// File: src/rmv_addsub.sv
// ----------------------------------------------------------------------------
// rmv_addsub
// Shared 64-bit adder / subtractor with carry and borrow out.
// ----------------------------------------------------------------------------
module rmv_addsub import rmv_pkg::*; (
  input  alu_op_t          op,
  input  logic [ALU_W-1:0] a,
  input  logic [ALU_W-1:0] b,
  output alu_res_t         res
);

  logic [ALU_W:0] ext;

  always_comb begin
    case (op)
      OP_ADD:  ext = {1'b0, a} + {1'b0, b};
      OP_SUB:  ext = {1'b0, a} - {1'b0, b};
      default: ext = '0;
    endcase
    res.carry = ext[ALU_W];
    res.value = ext[ALU_W-1:0];
  end

endmodule

// File: src/rmv_core.sv
// ----------------------------------------------------------------------------
// rmv_core
// Statistics registers and the sequencer that drives the shared adder through
// the mean divide, the deviation multiply and the variance divide.
// ----------------------------------------------------------------------------
module rmv_core import rmv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  core_ctl_t  ctl,
  input  in_item_t   item,
  output core_stat_t stat,
  output out_item_t  result
);

  state_t state, state_next;

  // Statistics
  logic [CNT_W-1:0]  count;
  logic [MEAN_W-1:0] mean;
  logic [SUM_W-1:0]  dev;
  logic [SMP_W-1:0]  min_val;
  logic [SMP_W-1:0]  max_val;
  logic [SUM_W-1:0]  total;

  // Work registers
  logic [MEAN_W-1:0] xf;
  logic              neg;
  logic [MEAN_W-1:0] mag;
  logic [SUM_W-1:0]  wq;       // dividend shifting out, quotient shifting in
  logic [CNT_W-1:0]  rem;
  logic [PROD_W-1:0] prod;
  logic [STEP_W-1:0] step;

  alu_op_t          alu_op;
  logic [ALU_W-1:0] alu_a, alu_b;
  alu_res_t         alu;

  logic [CNT_W:0]    rem_sh;
  logic [SMP_W-1:0]  x;
  logic [SUM_W:0]    total_sum;
  logic [SUM_W-1:0]  dev_new;
  logic              last_div, last_mul;

  rmv_addsub u_addsub (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu)
  );

  assign rem_sh    = {rem, wq[SUM_W-1]};
  assign x         = SMP_W'(item.sample[SAMPLE_W-1:0]);
  assign total_sum = {1'b0, total} + {{(SUM_W-SMP_W+1){1'b0}}, x};
  assign dev_new   = alu.carry ? '1 : alu.value;
  assign last_div  = (step == STEP_W'(DIV_STEPS - 1));
  assign last_mul  = (step == STEP_W'(MUL_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    alu_op     = OP_ADD;
    alu_a      = '0;
    alu_b      = '0;
    case (state)
      ST_IDLE: begin
        if (ctl.start) begin
          state_next = (item.command == CMD_CLEAR) ? ST_FIN : ST_CMP;
        end
      end
      ST_CMP: begin
        alu_op     = OP_SUB;
        alu_a      = ALU_W'(xf);
        alu_b      = ALU_W'(mean);
        state_next = ST_MAG;
      end
      ST_MAG: begin
        alu_op     = OP_SUB;
        alu_a      = neg ? ALU_W'(mean) : ALU_W'(xf);
        alu_b      = neg ? ALU_W'(xf) : ALU_W'(mean);
        state_next = ST_DIV;
      end
      ST_DIV, ST_VDIV: begin
        alu_op = OP_SUB;
        alu_a  = ALU_W'(rem_sh);
        alu_b  = ALU_W'(count);
        if (last_div) begin
          state_next = (state == ST_DIV) ? ST_MEAN : ST_FIN;
        end
      end
      ST_MEAN: begin
        alu_op     = neg ? OP_SUB : OP_ADD;
        alu_a      = ALU_W'(mean);
        alu_b      = ALU_W'(wq[MEAN_W-1:0]);
        state_next = ST_D2;
      end
      ST_D2: begin
        alu_op     = OP_SUB;
        alu_a      = neg ? ALU_W'(mean) : ALU_W'(xf);
        alu_b      = neg ? ALU_W'(xf) : ALU_W'(mean);
        state_next = ST_MUL;
      end
      ST_MUL: begin
        alu_op = OP_ADD;
        alu_a  = ALU_W'(prod[PROD_W-1:MEAN_W]);
        alu_b  = prod[0] ? ALU_W'(mag) : '0;
        if (last_mul) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        alu_op     = OP_ADD;
        alu_a      = dev;
        alu_b      = prod[PROD_W-1:2*FRAC_W];
        state_next = ST_VDIV;
      end
      ST_FIN: begin
        if (ctl.taken) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      mean    <= '0;
      dev     <= '0;
      min_val <= '0;
      max_val <= '0;
      total   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (ctl.start) begin
            if (item.command == CMD_CLEAR) begin
              count   <= '0;
              mean    <= '0;
              dev     <= '0;
              min_val <= '0;
              max_val <= '0;
              total   <= '0;
            end else begin
              if (count != '1) begin
                count <= count + CNT_W'(1);
              end
              total <= total_sum[SUM_W] ? '1 : total_sum[SUM_W-1:0];
              if (count == '0) begin
                min_val <= x;
                max_val <= x;
              end else begin
                if (x < min_val) min_val <= x;
                if (x > max_val) max_val <= x;
              end
            end
          end
        end
        ST_MEAN: mean <= alu.value[MEAN_W-1:0];
        ST_ACC:  dev  <= dev_new;
        default: ;
      endcase
    end
  end

  // Work registers carry no reset
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        xf   <= {x, {FRAC_W{1'b0}}};
        step <= '0;
      end
      ST_CMP: neg <= alu.carry;
      ST_MAG: begin
        mag  <= alu.value[MEAN_W-1:0];
        wq   <= SUM_W'(alu.value[MEAN_W-1:0]);
        rem  <= '0;
        step <= '0;
      end
      ST_DIV, ST_VDIV: begin
        // restore when the trial subtract borrows
        wq   <= {wq[SUM_W-2:0], ~alu.carry};
        rem  <= alu.carry ? rem_sh[CNT_W-1:0] : alu.value[CNT_W-1:0];
        step <= step + STEP_W'(1);
      end
      ST_D2: begin
        prod <= PROD_W'(alu.value[MEAN_W-1:0]);
        step <= '0;
      end
      ST_MUL: begin
        prod <= {alu.value[MEAN_W:0], prod[MEAN_W-1:1]};
        step <= step + STEP_W'(1);
      end
      ST_ACC: begin
        wq   <= dev_new;
        rem  <= '0;
        step <= '0;
      end
      default: ;
    endcase
  end

  assign stat.idle = (state == ST_IDLE);
  assign stat.done = (state == ST_FIN);

  always_comb begin
    result.sample_total   = count;
    result.mean_value     = mean;
    result.variance_value = (count >= CNT_W'(2)) ? wq : '0;
    result.smallest_seen  = min_val;
    result.largest_seen   = max_val;
    result.value_sum      = total;
  end

endmodule

// File: tb/running_mean_variance_stats_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_mean_variance_stats_tb
// Self-checking bench for the running mean / variance block. Sample and clear
// items go in under random valid gaps while stats_stall is pulled in random
// bursts, both off in the back-to-back test. A fixed-point Welford model in the
// bench predicts every statistics item, checked field by field in arrival order.
// ----------------------------------------------------------------------------
module running_mean_variance_stats_tb;
  import rmv_pkg::*;

  localparam int          RESET_CYCLES = 12;
  localparam int          SETTLE_CYCLES = 200;      // a little over one sample's work
  localparam int          CYCLE_LIMIT  = 1_500_000;
  localparam logic [63:0] SAMPLE_MASK  = (64'd1 << SAMPLE_W) - 64'd1;

  typedef enum int {
    SPREAD_FULL,
    SPREAD_LOW,
    SPREAD_HIGH,
    SPREAD_JITTER,
    SPREAD_EXTREME
  } spread_t;

  logic      clk;
  logic      rst          = 1'b1;
  logic      sample_valid = 1'b0;
  logic      sample_stall;
  in_item_t  sample_item  = '0;
  logic      stats_valid;
  logic      stats_stall  = 1'b0;
  out_item_t stats_item;

  // Running statistics as the block should hold them
  logic [CNT_W-1:0]  run_count = '0;
  logic [MEAN_W-1:0] run_mean  = '0;
  logic [SUM_W-1:0]  run_dev   = '0;
  logic [SMP_W-1:0]  run_min   = '0;
  logic [SMP_W-1:0]  run_max   = '0;
  logic [SUM_W-1:0]  run_total = '0;

  out_item_t expected_stats[$];
  int        fail_count = 0;
  int        stall_left = 0;
  int        cycle_count = 0;
  bit        idle_on = 1'b1;

  running_mean_variance_stats dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_item  (sample_item),
    .stats_valid  (stats_valid),
    .stats_stall  (stats_stall),
    .stats_item   (stats_item)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [SUM_W-1:0] add_saturated(input logic [SUM_W-1:0] a,
                                                     input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

  // Apply one item to the running statistics and return what the block reports.
  function automatic out_item_t update_stats(input in_item_t it);
    logic [SMP_W-1:0]  x;
    logic [MEAN_W-1:0] xf, mag, q, d2mag;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  term;
    logic              first, below;
    out_item_t         r;
    x = it.sample & SAMPLE_MASK[SMP_W-1:0];
    if (it.command == CMD_CLEAR) begin
      run_count = '0;
      run_mean  = '0;
      run_dev   = '0;
      run_min   = '0;
      run_max   = '0;
      run_total = '0;
    end else begin
      first = (run_count == '0);
      if (run_count != '1) run_count = run_count + CNT_W'(1);
      xf    = MEAN_W'(x) << FRAC_W;
      below = xf < run_mean;
      mag   = below ? run_mean - xf : xf - run_mean;
      q     = mag / MEAN_W'(run_count);
      run_mean = below ? run_mean - q : run_mean + q;
      d2mag = below ? run_mean - xf : xf - run_mean;
      prod  = (PROD_W'(mag) * PROD_W'(d2mag)) >> (2 * FRAC_W);
      term  = (prod[PROD_W-1:SUM_W] != '0) ? '1 : prod[SUM_W-1:0];
      run_dev   = add_saturated(run_dev, term);
      run_total = add_saturated(run_total, SUM_W'(x));
      if (first || x < run_min) run_min = x;
      if (first || x > run_max) run_max = x;
    end
    r.sample_total   = run_count;
    r.mean_value     = run_mean;
    r.variance_value = (run_count >= CNT_W'(2)) ? run_dev / SUM_W'(run_count) : '0;
    r.smallest_seen  = run_min;
    r.largest_seen   = run_max;
    r.value_sum      = run_total;
    return r;
  endfunction

  function automatic logic [SMP_W-1:0] draw_sample(input spread_t spread,
                                                   input logic [SMP_W-1:0] base);
    case (spread)
      SPREAD_LOW:     return SMP_W'($urandom_range(0, 255));
      SPREAD_HIGH:    return '1 - SMP_W'($urandom_range(0, 255));
      SPREAD_JITTER:  return base ^ SMP_W'($urandom_range(0, 1023));
      SPREAD_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
      default:        return $urandom;
    endcase
  endfunction

  // Hold the item until accepted; valid stays high into the next call.
  task automatic send_item(input logic cmd, input logic [SMP_W-1:0] value);
    in_item_t it;
    it.command = cmd;
    it.sample  = value;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_item  <= it;
    do @(posedge clk); while (sample_stall);
    expected_stats.insert(expected_stats.size(), update_stats(it));
  endtask

  task automatic wait_drained();
    sample_valid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_item(CMD_CLEAR, 32'h0000_0000);   // clear on empty statistics
    send_item(CMD_ADD,   32'h0000_0000);   // first sample of zero
    send_item(CMD_CLEAR, 32'hFFFF_FFFF);   // sample field ignored on clear
    send_item(CMD_ADD,   32'hFFFF_FFFF);   // first sample sets min and max
    // alternate extremes until the deviation sum saturates
    repeat (3) begin
      send_item(CMD_ADD, 32'h0000_0000);
      send_item(CMD_ADD, 32'hFFFF_FFFF);
    end
    send_item(CMD_ADD,   32'h0000_0001);
    send_item(CMD_CLEAR, 32'h1234_5678);
    repeat (3) send_item(CMD_ADD, 32'd5);  // no spread, zero variance
    send_item(CMD_ADD,   32'd7);
    send_item(CMD_CLEAR, 32'h0);
    send_item(CMD_ADD,   32'h8000_0000);
    send_item(CMD_ADD,   32'h7FFF_FFFF);
    send_item(CMD_ADD,   32'h5555_5555);
    send_item(CMD_ADD,   32'hAAAA_AAAA);
    send_item(CMD_CLEAR, 32'h0);
  endtask

  // Clear, then a run of samples from one spread.
  task automatic test_welford_runs(input int n_items);
    int               sent;
    int               run_len;
    spread_t          spread;
    logic [SMP_W-1:0] base;
    sent = 0;
    while (sent < n_items) begin
      send_item(CMD_CLEAR, $urandom);
      sent++;
      run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
      spread  = spread_t'($urandom_range(0, SPREAD_EXTREME));
      base    = $urandom;
      repeat (run_len) begin
        send_item(CMD_ADD, draw_sample(spread, base));
        sent++;
      end
    end
  endtask

  // Unrelated samples and clears at random.
  task automatic test_mixed_noise(input int n_items);
    repeat (n_items) begin
      if ($urandom_range(0, 7) == 0)
        send_item(CMD_CLEAR, $urandom);
      else
        send_item(CMD_ADD, draw_sample(spread_t'($urandom_range(0, SPREAD_EXTREME)),
                                       $urandom));
    end
  endtask

  // Let the block run dry between short bursts.
  task automatic test_drain_pause();
    repeat (3) begin
      repeat ($urandom_range(5, 12))
        send_item(CMD_ADD, draw_sample(spread_t'($urandom_range(0, SPREAD_EXTREME)),
                                       $urandom));
      wait_drained();
    end
    send_item(CMD_CLEAR, $urandom);
    wait_drained();
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    test_welford_runs(100);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_welford_runs(720);
    test_drain_pause();
    test_mixed_noise(270);
    test_back_to_back();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_stats.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : stats_monitor
    out_item_t want;
    if (!rst && stats_valid === 1'b1 && !stats_stall) begin
      if (expected_stats.size() == 0) begin
        $display("%0t: stats item with none expected, actual %h", $time, stats_item);
        fail_count++;
      end else begin
        want = expected_stats.pop_front();
        check_field("sample_total",   64'(want.sample_total),
                    64'(stats_item.sample_total));
        check_field("mean_value",     64'(want.mean_value),
                    64'(stats_item.mean_value));
        check_field("variance_value", want.variance_value, stats_item.variance_value);
        check_field("smallest_seen",  64'(want.smallest_seen),
                    64'(stats_item.smallest_seen));
        check_field("largest_seen",   64'(want.largest_seen),
                    64'(stats_item.largest_seen));
        check_field("value_sum",      want.value_sum,      stats_item.value_sum);
      end
    end
    // stall in bursts, independent of stats_valid
    if (stall_left > 0) begin
      stall_left--;
      stats_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 9);
      stats_stall <= 1'b1;
    end else begin
      stats_stall <= 1'b0;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: cycle limit reached, %0d stats items outstanding", $time,
             expected_stats.size());
    $display("simulation failed");
    $finish;
  end

endmodule
